/* rtl/csp_pkg.sv */
`timescale 1ns / 1ps

package csp_pkg;

  // character width of the text and how much of it the grammar looks at
  localparam int CH_W      = 16;
  localparam int CHAR_BITS = 16;
  localparam int CODE_W    = 32;
  localparam int QDEPTH    = 2;

  localparam logic [CH_W-1:0] CHAR_MASK =
    (CHAR_BITS >= CH_W) ? {CH_W{1'b1}} : CH_W'((64'd1 << CHAR_BITS) - 64'd1);

  // status codes of a result word
  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // characters the grammar knows
  localparam logic [CH_W-1:0] C_NUL    = CH_W'(8'h00);
  localparam logic [CH_W-1:0] C_TAB    = CH_W'(8'h09);
  localparam logic [CH_W-1:0] C_NL     = CH_W'(8'h0A);
  localparam logic [CH_W-1:0] C_CR     = CH_W'(8'h0D);
  localparam logic [CH_W-1:0] C_SP     = CH_W'(8'h20);
  localparam logic [CH_W-1:0] C_DQ     = CH_W'(8'h22);
  localparam logic [CH_W-1:0] C_SQ     = CH_W'(8'h27);
  localparam logic [CH_W-1:0] C_COMMA  = CH_W'(8'h2C);
  localparam logic [CH_W-1:0] C_ZERO   = CH_W'(8'h30);
  localparam logic [CH_W-1:0] C_NINE   = CH_W'(8'h39);
  localparam logic [CH_W-1:0] C_SEMI   = CH_W'(8'h3B);
  localparam logic [CH_W-1:0] C_UA     = CH_W'(8'h41);
  localparam logic [CH_W-1:0] C_UF     = CH_W'(8'h46);
  localparam logic [CH_W-1:0] C_UN     = CH_W'(8'h4E);
  localparam logic [CH_W-1:0] C_UR     = CH_W'(8'h52);
  localparam logic [CH_W-1:0] C_US     = CH_W'(8'h53);
  localparam logic [CH_W-1:0] C_UT     = CH_W'(8'h54);
  localparam logic [CH_W-1:0] C_UX     = CH_W'(8'h58);
  localparam logic [CH_W-1:0] C_UZ     = CH_W'(8'h5A);
  localparam logic [CH_W-1:0] C_LBR    = CH_W'(8'h5B);
  localparam logic [CH_W-1:0] C_BSL    = CH_W'(8'h5C);
  localparam logic [CH_W-1:0] C_RBR    = CH_W'(8'h5D);
  localparam logic [CH_W-1:0] C_USCORE = CH_W'(8'h5F);
  localparam logic [CH_W-1:0] C_LA     = CH_W'(8'h61);
  localparam logic [CH_W-1:0] C_LF     = CH_W'(8'h66);
  localparam logic [CH_W-1:0] C_LN     = CH_W'(8'h6E);
  localparam logic [CH_W-1:0] C_LR     = CH_W'(8'h72);
  localparam logic [CH_W-1:0] C_LS     = CH_W'(8'h73);
  localparam logic [CH_W-1:0] C_LT     = CH_W'(8'h74);
  localparam logic [CH_W-1:0] C_LX     = CH_W'(8'h78);
  localparam logic [CH_W-1:0] C_LZ     = CH_W'(8'h7A);

  // character class as seen outside a word or literal
  typedef enum logic [3:0] {
    CK_DIGIT  = 4'd0,
    CK_SQUOTE = 4'd1,
    CK_DQUOTE = 4'd2,
    CK_LBRACK = 4'd3,
    CK_RBRACK = 4'd4,
    CK_SEP    = 4'd5,
    CK_SPACE  = 4'd6,
    CK_BSLASH = 4'd7,
    CK_OTHER  = 4'd8
  } ck_t;

  // classified character, handed from front end to back end
  typedef struct packed {
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] esc_val;
    logic [3:0]      dval;
    logic            is_digit;
    logic            is_word;
    logic            is_hex;
    logic            is_x;
    logic            is_last;
    ck_t             kind;
  } csp_cls_t;

endpackage

/* rtl/csp_intf.sv */
`timescale 1ns / 1ps

interface csp_in_if import csp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            is_last;

  modport source (output valid, ch, is_last, input ready);
  modport sink (input valid, ch, is_last, output ready);
endinterface

interface csp_out_if import csp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              emit;
  logic [CODE_W-1:0] first_code;
  logic [CODE_W-1:0] last_code;
  logic [1:0]        status;

  modport source (output valid, emit, first_code, last_code, status, input ready);
  modport sink (input valid, emit, first_code, last_code, status, output ready);
endinterface

/* rtl/csp_front.sv */
`timescale 1ns / 1ps

module csp_front import csp_pkg::*; (
  csp_in_if.sink   in_w,
  input  logic     q_ready,
  output logic     q_push,
  output csp_cls_t q_wdata
);

  logic [CH_W-1:0] c;
  logic            is_dig;
  logic            is_up;
  logic            is_lo;
  logic            is_hexl;

  assign in_w.ready = q_ready;
  assign q_push     = in_w.valid && q_ready;

  always_comb begin
    c       = in_w.ch & CHAR_MASK;
    is_dig  = (c >= C_ZERO) && (c <= C_NINE);
    is_up   = (c >= C_UA) && (c <= C_UZ);
    is_lo   = (c >= C_LA) && (c <= C_LZ);
    is_hexl = ((c >= C_UA) && (c <= C_UF)) || ((c >= C_LA) && (c <= C_LF));

    q_wdata          = '0;
    q_wdata.c        = c;
    q_wdata.is_digit = is_dig;
    q_wdata.is_word  = is_dig || is_up || is_lo || (c == C_USCORE);
    q_wdata.is_hex   = is_dig || is_hexl;
    q_wdata.is_x     = (c == C_LX) || (c == C_UX);
    q_wdata.is_last  = in_w.is_last;
    // letters a-f sit at low nibble 1..6, digits at 0..9
    q_wdata.dval     = is_dig ? c[3:0] : (c[3:0] + 4'd9);

    unique case (c) inside
      C_ZERO:       q_wdata.esc_val = C_NUL;
      C_LN, C_UN:   q_wdata.esc_val = C_NL;
      C_LR, C_UR:   q_wdata.esc_val = C_CR;
      C_LS, C_US:   q_wdata.esc_val = C_SP;
      C_LT, C_UT:   q_wdata.esc_val = C_TAB;
      default:      q_wdata.esc_val = c;
    endcase
    q_wdata.esc_val = q_wdata.esc_val & CHAR_MASK;

    if (is_dig) begin
      q_wdata.kind = CK_DIGIT;
    end else begin
      unique case (c) inside
        C_SQ:                    q_wdata.kind = CK_SQUOTE;
        C_DQ:                    q_wdata.kind = CK_DQUOTE;
        C_LBR:                   q_wdata.kind = CK_LBRACK;
        C_RBR:                   q_wdata.kind = CK_RBRACK;
        C_COMMA, C_SEMI:         q_wdata.kind = CK_SEP;
        C_SP, C_NL, C_CR, C_TAB: q_wdata.kind = CK_SPACE;
        C_BSL:                   q_wdata.kind = CK_BSLASH;
        default:                 q_wdata.kind = CK_OTHER;
      endcase
    end
  end

endmodule

/* rtl/csp_queue.sv */
`timescale 1ns / 1ps

module csp_queue import csp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  csp_cls_t wdata,
  output logic     ready,
  input  logic     pop,
  output logic     rvalid,
  output csp_cls_t rdata
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  csp_cls_t         mem_r [QDEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign ready  = (cnt_r != CNT_W'(QDEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue popped while empty");

  a_cnt_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count lost a push");

endmodule

/* rtl/csp_back.sv */
`timescale 1ns / 1ps

module csp_back import csp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      q_valid,
  input  csp_cls_t  q_rdata,
  output logic      q_pop,
  csp_out_if.source out_w
);

  typedef enum logic [5:0] {
    PS_CLEAR   = 6'b000001,
    PS_TIGHT   = 6'b000010,
    PS_BRACKET = 6'b000100,
    PS_START   = 6'b001000,
    PS_SEP     = 6'b010000,
    PS_END     = 6'b100000
  } ps_t;

  typedef enum logic [2:0] {
    LM_NONE   = 3'b001,
    LM_SINGLE = 3'b010,
    LM_STRING = 3'b100
  } lm_t;

  typedef struct packed {
    ps_t               ps;
    logic [CODE_W-1:0] num;
    logic              w_in;
    logic              w_hex;
    logic              w_inv;
    logic              w_pre;
    logic [1:0]        wlen;
    logic [CODE_W-1:0] rstart;
    lm_t               lm;
    logic              esc;
    logic [CH_W-1:0]   lchar;
    logic [1:0]        lcnt;
    logic              failed;
  } csp_st_t;

  typedef struct packed {
    csp_st_t           st;
    logic              emit;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
  } csp_wk_t;

  function automatic csp_st_t f_clear();
    csp_st_t s;
    s        = '0;
    s.ps     = PS_CLEAR;
    s.lm     = LM_NONE;
    return s;
  endfunction

  function automatic csp_wk_t f_report(csp_wk_t w, logic [CODE_W-1:0] a,
                                       logic [CODE_W-1:0] b);
    w.emit  = 1'b1;
    w.first = a;
    w.last  = b;
    return w;
  endfunction

  function automatic csp_wk_t f_take(csp_wk_t w, logic [CODE_W-1:0] v, logic keep);
    unique case (w.st.ps)
      PS_CLEAR: begin
        if (keep) w = f_report(w, v, v);
        w.st.ps = PS_TIGHT;
      end
      PS_BRACKET: begin
        w.st.rstart = v;
        w.st.ps     = PS_START;
      end
      PS_SEP: begin
        if (w.st.rstart <= v) w = f_report(w, w.st.rstart, v);
        w.st.ps = PS_END;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic csp_wk_t f_word_add(csp_wk_t w, csp_cls_t k);
    logic [1:0] idx;
    idx = w.st.wlen;
    if (w.st.wlen != 2'd3) w.st.wlen = w.st.wlen + 2'd1;
    if (idx == 2'd0) begin
      w.st.w_pre = (k.c == C_ZERO);
      w.st.num   = k.is_digit ? CODE_W'(k.dval) : '0;
      if (!k.is_digit) w.st.w_inv = 1'b1;
    end else if (idx == 2'd1 && w.st.w_pre && k.is_x) begin
      w.st.w_hex = 1'b1;
      w.st.num   = '0;
    end else if (w.st.w_hex) begin
      if (k.is_hex) w.st.num = (w.st.num << 4) + CODE_W'(k.dval);
      else w.st.w_inv = 1'b1;
    end else if (k.is_digit) begin
      // times ten as two shifts
      w.st.num = (w.st.num << 3) + (w.st.num << 1) + CODE_W'(k.dval);
    end else begin
      w.st.w_inv = 1'b1;
    end
    return w;
  endfunction

  function automatic csp_wk_t f_word_finish(csp_wk_t w);
    logic              bad;
    logic [CODE_W-1:0] v;
    bad        = w.st.w_inv;
    v          = w.st.num;
    w.st.w_in  = 1'b0;
    w.st.w_hex = 1'b0;
    w.st.w_inv = 1'b0;
    w.st.w_pre = 1'b0;
    w.st.wlen  = '0;
    w.st.num   = '0;
    if (bad) w.st.failed = 1'b1;
    else w = f_take(w, v, !v[CODE_W-1]);
    return w;
  endfunction

  function automatic csp_wk_t f_lit_in(csp_wk_t w, logic [CH_W-1:0] v);
    if (w.st.lm == LM_STRING) begin
      w = f_report(w, CODE_W'(v), CODE_W'(v));
    end else begin
      if (w.st.lcnt == 2'd0) w.st.lchar = v;
      if (w.st.lcnt != 2'd2) w.st.lcnt = w.st.lcnt + 2'd1;
    end
    return w;
  endfunction

  function automatic csp_wk_t f_literal(csp_wk_t w, csp_cls_t k);
    logic term;
    term = (w.st.lm == LM_SINGLE) ? (k.kind == CK_SQUOTE) : (k.kind == CK_DQUOTE);
    if (w.st.esc) begin
      w.st.esc = 1'b0;
      w = f_lit_in(w, k.esc_val);
    end else if (term) begin
      if (w.st.lm == LM_SINGLE) begin
        if (w.st.lcnt == 2'd1) w = f_take(w, CODE_W'(w.st.lchar), w.st.lchar != '0);
        else w.st.failed = 1'b1;
      end else begin
        w.st.ps = PS_TIGHT;
      end
      w.st.lm    = LM_NONE;
      w.st.lcnt  = '0;
      w.st.lchar = '0;
    end else if (k.kind == CK_BSLASH) begin
      w.st.esc = 1'b1;
    end else begin
      w = f_lit_in(w, k.c);
    end
    return w;
  endfunction

  function automatic csp_wk_t f_dispatch(csp_wk_t w, csp_cls_t k, logic dis);
    logic va;
    va = (w.st.ps == PS_CLEAR) || (w.st.ps == PS_BRACKET) || (w.st.ps == PS_SEP);
    unique case (k.kind)
      CK_DIGIT: begin
        if (!va) begin
          w.st.failed = 1'b1;
        end else begin
          w.st.w_in = 1'b1;
          w = f_word_add(w, k);
        end
      end
      CK_SQUOTE: begin
        if (!va || dis) begin
          w.st.failed = 1'b1;
        end else begin
          w.st.lm   = LM_SINGLE;
          w.st.lcnt = '0;
        end
      end
      CK_DQUOTE: begin
        if (w.st.ps != PS_CLEAR || dis) w.st.failed = 1'b1;
        else w.st.lm = LM_STRING;
      end
      CK_LBRACK: begin
        if (w.st.ps != PS_CLEAR) w.st.failed = 1'b1;
        else w.st.ps = PS_BRACKET;
      end
      CK_RBRACK: begin
        if (w.st.ps != PS_END) w.st.failed = 1'b1;
        else w.st.ps = PS_TIGHT;
      end
      CK_SEP: begin
        if (w.st.ps == PS_START) w.st.ps = PS_SEP;
        else if (w.st.ps == PS_TIGHT) w.st.ps = PS_CLEAR;
        else if (w.st.ps != PS_CLEAR) w.st.failed = 1'b1;
      end
      CK_SPACE: begin
        if (w.st.ps == PS_TIGHT) w.st.ps = PS_CLEAR;
      end
      default: w.st.failed = 1'b1;
    endcase
    return w;
  endfunction

  csp_st_t           st_r, st_nxt;
  logic              dis_r;
  logic              out_valid_r;
  logic              out_emit_r, out_emit_nxt;
  logic [CODE_W-1:0] out_first_r, out_first_nxt;
  logic [CODE_W-1:0] out_last_r, out_last_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  csp_wk_t           wk;

  assign q_pop = q_valid && (!out_valid_r || out_w.ready);

  always_comb begin
    wk.st    = st_r;
    wk.emit  = 1'b0;
    wk.first = '0;
    wk.last  = '0;
    out_status_nxt = ST_PARSING;

    if (!wk.st.failed) begin
      if (wk.st.lm != LM_NONE) begin
        wk = f_literal(wk, q_rdata);
      end else if (wk.st.w_in && q_rdata.is_word) begin
        wk = f_word_add(wk, q_rdata);
      end else begin
        if (wk.st.w_in) wk = f_word_finish(wk);
        if (!wk.st.failed) wk = f_dispatch(wk, q_rdata, dis_r);
      end
    end

    if (q_rdata.is_last) begin
      if (!wk.st.failed && wk.st.w_in) wk = f_word_finish(wk);
      if (!wk.st.failed && wk.st.lm == LM_NONE &&
          (wk.st.ps == PS_CLEAR || wk.st.ps == PS_TIGHT)) begin
        out_status_nxt = ST_ACCEPT;
      end else begin
        out_status_nxt = ST_REJECT;
      end
      wk.st = f_clear();
    end

    st_nxt        = q_pop ? wk.st : st_r;
    out_emit_nxt  = wk.emit;
    out_first_nxt = wk.first;
    out_last_nxt  = wk.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= f_clear();
      dis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) dis_r <= cfg_wdata;
      if (q_pop) out_valid_r <= 1'b1;
      else if (out_w.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_emit_r   <= out_emit_nxt;
      out_first_r  <= out_first_nxt;
      out_last_r   <= out_last_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_w.valid      = out_valid_r;
  assign out_w.emit       = out_emit_r;
  assign out_w.first_code = out_first_r;
  assign out_w.last_code  = out_last_r;
  assign out_w.status     = out_status_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_rdata.is_last) |=>
      (st_r.ps == PS_CLEAR && st_r.lm == LM_NONE && !st_r.failed && !st_r.w_in))
    else $error("parser not back to clear after last word");

  a_esc_in_lit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.esc |-> st_r.lm != LM_NONE)
    else $error("escape pending outside a literal");

  a_lit_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.lm != LM_NONE |-> !st_r.w_in)
    else $error("literal open while a number is open");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_emit_r) |-> out_first_r <= out_last_r)
    else $error("emitted range is reversed");

endmodule

/* rtl/charset_spec_parser.sv */
`timescale 1ns / 1ps

// Character-set specification parser. Text comes in one UTF-16 character per
// word on in_ch, the final character flagged by is_last; every input word gives
// exactly one result word on out_res, in order. A result carries at most one
// code point range (emit, first_code, last_code; single code points have both
// ends equal, ranges are never expanded) and, on the last character, the
// verdict in status (1 accepted, 2 rejected, 0 otherwise). After the last
// character the parser is back at its reset state and the next text may
// follow at once. The block sustains one character per clock while out_res
// is not stalled: the front end classifies the character in the cycle it is
// accepted, a two-entry queue decouples it from the back end, and the back
// end does the whole parser state update for one character combinationally
// into its output register, which is the loop that sets the rate. A result
// is valid once its character has passed the queue entry and the output
// register. cfg_wdata written with cfg_we sets disable_char_literals (quoted
// literals then reject the text); write it only while no text is in flight.
module charset_spec_parser import csp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  csp_in_if.sink     in_ch,
  csp_out_if.source  out_res,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  // front end to queue
  logic     q_push;
  logic     q_ready;
  csp_cls_t q_wdata;

  // queue to back end
  logic     q_pop;
  logic     q_valid;
  csp_cls_t q_rdata;

  // classify each character as it is accepted
  csp_front u_front (
    .in_w    (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // short queue so input and output stalls stay independent
  csp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .ready  (q_ready),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // parser state, config register and output register
  csp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_w     (out_res)
  );

endmodule
